/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen, off while reset is held
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/dtcr_pkg.sv */
`timescale 1ns / 1ps
package dtcr_pkg;

	// field widths
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int DEPTH_W = 16;
	localparam int REG_W   = 20;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 40;

	// stages ahead of the divider inside one axis
	localparam int PRE_STAGES = 6;

	// smallest depth that gives a positive z
	localparam logic [DEPTH_W-1:0] MIN_DEPTH = 16'd3;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH_FOCAL_X  = 3'd0,
		REG_DEPTH_FOCAL_Y  = 3'd1,
		REG_DEPTH_CENTER_X = 3'd2,
		REG_DEPTH_CENTER_Y = 3'd3,
		REG_COLOR_FOCAL_X  = 3'd4,
		REG_COLOR_FOCAL_Y  = 3'd5,
		REG_COLOR_CENTER_X = 3'd6,
		REG_COLOR_CENTER_Y = 3'd7
	} reg_idx_t;

	// reset values, Q12.8
	localparam logic [REG_W-1:0] RST_FOCAL    = 20'd157286;
	localparam logic [REG_W-1:0] RST_CENTER_X = 20'd81920;
	localparam logic [REG_W-1:0] RST_CENTER_Y = 20'd61440;

	// one camera axis worth of intrinsics
	typedef struct packed {
		logic [REG_W-1:0] focal_d;
		logic [REG_W-1:0] center_d;
		logic [REG_W-1:0] focal_c;
		logic [REG_W-1:0] center_c;
	} axis_cfg_t;

endpackage

/* hw/rtl/dtcr_axis.sv */
`timescale 1ns / 1ps
// One axis of the reprojection: back-project, shift, project, then a
// restoring divider with one quotient bit per stage.
module dtcr_axis import dtcr_pkg::*; #(
	parameter int QW = 10
) (
	input  logic               clk,
	input  logic               en,
	input  logic [COL_W-1:0]   pix,
	input  logic [DEPTH_W-1:0] depth,
	input  axis_cfg_t          cfg,
	input  logic               add_ofs,
	output logic [QW-1:0]      q,
	output logic               ok
);

	logic signed [21:0] a_s1;
	logic signed [20:0] e_s1;
	logic [DEPTH_W-1:0] dep_s1;
	logic signed [38:0] p1_s2;
	logic signed [41:0] d_s2;
	logic [23:0]        ofs_s2;
	logic signed [39:0] n_s3;
	logic signed [41:0] d_s3;
	logic signed [60:0] t1_s4;
	logic signed [63:0] t2_s4;
	logic signed [41:0] d_s4;
	logic signed [63:0] num_s5;
	logic signed [41:0] d_s5;

	logic [20:0]        ten_dep;
	logic [23:0]        fd_ext;
	logic [21:0]        cc128;
	logic signed [63:0] t1_ext;
	logic [63:0]        d_u5;
	logic [63:0]        lim5;

	// divider stages, index 0 is the sixth pipeline stage
	logic [63:0]        rem_s [QW+1];
	logic [63:0]        div_s [QW+1];
	logic [QW-1:0]      quo_s [QW+1];
	logic               ok_s  [QW+1];

	assign ten_dep = ({5'b0, depth} << 3) + ({5'b0, depth} << 1);
	assign fd_ext  = {4'b0, cfg.focal_d};
	assign cc128   = {2'b0, cfg.center_c} + 22'd128;
	assign t1_ext  = {{3{t1_s4[60]}}, t1_s4};
	assign d_u5    = {22'b0, d_s5};
	assign lim5    = d_u5 << (8 + QW);

	// arithmetic pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= $signed({4'b0, pix, 8'b0}) - $signed({2'b0, cfg.center_d});
			e_s1   <= $signed(ten_dep - 21'd27);
			dep_s1 <= depth;

			p1_s2  <= a_s1 * $signed({1'b0, dep_s1});
			d_s2   <= $signed({1'b0, cfg.focal_d}) * e_s1;
			ofs_s2 <= add_ofs ? (fd_ext << 4) - fd_ext : 24'd0;

			n_s3   <= {p1_s2[38], p1_s2} + $signed({16'b0, ofs_s2});
			d_s3   <= d_s2;

			t1_s4  <= n_s3 * $signed({1'b0, cfg.focal_c});
			t2_s4  <= $signed(cc128) * d_s3;
			d_s4   <= d_s3;

			num_s5 <= (t1_ext <<< 3) + (t1_ext <<< 1) + t2_s4;
			d_s5   <= d_s4;

			// numerator must be positive and the quotient below 2^QW
			ok_s[0]  <= (num_s5 > 64'sd0) && ($unsigned(num_s5) < lim5);
			rem_s[0] <= $unsigned(num_s5);
			div_s[0] <= d_u5 << 8;
			quo_s[0] <= '0;
		end
	end

	// restoring divider, one bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [63:0] sub;
		assign sub = div_s[k] << (QW - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= sub) begin
					rem_s[k+1] <= rem_s[k] - sub;
					quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_s[k];
					quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b0};
				end
				div_s[k+1] <= div_s[k];
				ok_s[k+1]  <= ok_s[k];
			end
		end
	end

	assign q  = quo_s[QW];
	assign ok = ok_s[QW];

endmodule

/* hw/rtl/depth_to_color_reprojection_unit.sv */
`timescale 1ns / 1ps
// Throughput: one word per cycle; the whole pipeline advances together and
// holds only while a finished word waits and the output is not ready.
// The pipeline ends in a restoring divider, one quotient bit per stage.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// default intrinsics.
module depth_to_color_reprojection_unit import dtcr_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // pixel_col[9:0], pixel_row[18:10], depth_mm[34:19]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // write_valid[0], target_col[10:1],
	                                    // target_row[19:11], depth_out[35:20]
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_addr,
	input  logic [REG_W-1:0] cfg_wdata
);

	localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
	localparam int QW      = $clog2(MAX_DIM);
	localparam int LAT     = PRE_STAGES + QW;
	localparam logic [QW:0] FW_L = (QW+1)'(FRAME_WIDTH);
	localparam logic [QW:0] FH_L = (QW+1)'(FRAME_HEIGHT);

	logic [REG_W-1:0] regs_q [8];
	axis_cfg_t        cfg_x, cfg_y;

	logic             en;
	logic [COL_W-1:0] in_col;
	logic [COL_W-1:0] in_row;
	logic [DEPTH_W-1:0] in_dep;
	logic             in_live;

	logic             vld_s  [LAT];
	logic             live_s [LAT];
	logic [DEPTH_W-1:0] dep_s [LAT];

	logic [QW-1:0]    qx, qy;
	logic             okx, oky;
	logic             wr_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_DEPTH_FOCAL_X]  <= RST_FOCAL;
			regs_q[REG_DEPTH_FOCAL_Y]  <= RST_FOCAL;
			regs_q[REG_DEPTH_CENTER_X] <= RST_CENTER_X;
			regs_q[REG_DEPTH_CENTER_Y] <= RST_CENTER_Y;
			regs_q[REG_COLOR_FOCAL_X]  <= RST_FOCAL;
			regs_q[REG_COLOR_FOCAL_Y]  <= RST_FOCAL;
			regs_q[REG_COLOR_CENTER_X] <= RST_CENTER_X;
			regs_q[REG_COLOR_CENTER_Y] <= RST_CENTER_Y;
		end else if (cfg_we) begin
			regs_q[cfg_addr] <= cfg_wdata;
		end
	end

	assign cfg_x = '{focal_d:  regs_q[REG_DEPTH_FOCAL_X],
	                 center_d: regs_q[REG_DEPTH_CENTER_X],
	                 focal_c:  regs_q[REG_COLOR_FOCAL_X],
	                 center_c: regs_q[REG_COLOR_CENTER_X]};
	assign cfg_y = '{focal_d:  regs_q[REG_DEPTH_FOCAL_Y],
	                 center_d: regs_q[REG_DEPTH_CENTER_Y],
	                 focal_c:  regs_q[REG_COLOR_FOCAL_Y],
	                 center_c: regs_q[REG_COLOR_CENTER_Y]};

	// input unpack and global advance
	assign in_col   = s_tdata[9:0];
	assign in_row   = {1'b0, s_tdata[18:10]};
	assign in_dep   = s_tdata[34:19];
	assign in_live  = (in_dep >= MIN_DEPTH) && (cfg_x.focal_d != '0)
	                  && (cfg_y.focal_d != '0);
	assign en       = !vld_s[LAT-1] || m_tready;
	assign s_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// side payload line
	always_ff @(posedge clk) begin
		if (en) begin
			live_s[0] <= in_live;
			dep_s[0]  <= in_dep;
			for (int i = 1; i < LAT; i++) begin
				live_s[i] <= live_s[i-1];
				dep_s[i]  <= dep_s[i-1];
			end
		end
	end

	dtcr_axis #(.QW(QW)) u_axis_x (
		.clk(clk), .en(en), .pix(in_col), .depth(in_dep), .cfg(cfg_x),
		.add_ofs(1'b1), .q(qx), .ok(okx)
	);

	dtcr_axis #(.QW(QW)) u_axis_y (
		.clk(clk), .en(en), .pix(in_row), .depth(in_dep), .cfg(cfg_y),
		.add_ofs(1'b0), .q(qy), .ok(oky)
	);

	// bounds check and output pack
	assign wr_ok = live_s[LAT-1] && okx && oky
	               && (qx != '0) && ({1'b0, qx} < FW_L)
	               && (qy != '0) && ({1'b0, qy} < FH_L);

	assign m_tvalid = vld_s[LAT-1];
	assign m_tdata  = {4'b0, dep_s[LAT-1],
	                   wr_ok ? ROW_W'(qy) : {ROW_W{1'b0}},
	                   wr_ok ? COL_W'(qx) : {COL_W{1'b0}},
	                   wr_ok};

endmodule

/* hw/rtl/dtcr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtcr_checker import dtcr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             cfg_we,
	input logic [IDX_W-1:0] cfg_addr,
	input logic [REG_W-1:0] cfg_wdata
);

	// a stalled word holds
	`CHK_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed under stall")
	// input side opens whenever the output can move
	`CHK_ASSERT(a_ready, clk, arst_n, s_tready == (!m_tvalid || m_tready), "input ready does not follow output")
	// a write needs a positive z
	`CHK_NEVER(a_depth, clk, arst_n, m_tvalid && m_tdata[0] && (m_tdata[35:20] < MIN_DEPTH), "write with depth below 3")
	// a dropped word carries no target
	`CHK_NEVER(a_zero, clk, arst_n, m_tvalid && !m_tdata[0] && (m_tdata[19:1] != '0), "target set on invalid word")

endmodule

bind depth_to_color_reprojection_unit dtcr_checker u_dtcr_checker (.*);

/* tb/sv/depth_to_color_reprojection_unit_tb.sv */
`timescale 1ns / 1ps
module depth_to_color_reprojection_unit_tb;
	import dtcr_pkg::*;

	localparam int FRAME_W     = 640;
	localparam int FRAME_H     = 480;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1750;
	localparam int NUM_SETUPS  = 6;

	// same bit order as m_tdata, write_valid in the lowest bit
	typedef struct packed {
		logic [DEPTH_W-1:0]   depth_out;
		logic [ROW_W-1:0]     target_row;
		logic [COL_W-1:0]     target_col;
		logic                 write_valid;
	} target_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_addr = REG_DEPTH_FOCAL_X;
	logic [REG_W-1:0] cfg_wdata = '0;

	// pixel words waiting to be sent, targets waiting to come back
	logic [IN_W-1:0]  pixel_q[$];
	target_t          target_q[$];
	logic [REG_W-1:0] intrinsics[8];
	int               src_idle_pct = 0;
	int               snk_idle_pct = 0;
	logic             snk_hold = 1'b0;
	int               errors = 0;
	longint           cycles = 0;

	depth_to_color_reprojection_unit #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) dut (.*);

	always #6 clk = ~clk;

	// one axis: back-project, shift, re-project, round toward zero
	function automatic longint reproject_axis(longint pix, longint dep, longint fd,
			longint cd, longint fc, longint cc, longint off_mm);
		longint n;
		longint d;
		longint num;
		n = (pix * 256 - cd) * dep + off_mm * fd;
		d = fd * (10 * dep - 27);
		num = 10 * n * fc + (cc + 128) * d;
		return num / (256 * d);
	endfunction

	function automatic target_t predict_target(logic [IN_W-1:0] w);
		target_t t;
		longint  col;
		longint  row;
		longint  dep;
		longint  u;
		longint  v;
		col = longint'(w[9:0]);
		row = longint'(w[18:10]);
		dep = longint'(w[34:19]);
		t = '0;
		t.depth_out = w[34:19];
		if (dep >= 3 && intrinsics[REG_DEPTH_FOCAL_X] != 0
				&& intrinsics[REG_DEPTH_FOCAL_Y] != 0) begin
			u = reproject_axis(col, dep, longint'(intrinsics[REG_DEPTH_FOCAL_X]),
				longint'(intrinsics[REG_DEPTH_CENTER_X]),
				longint'(intrinsics[REG_COLOR_FOCAL_X]),
				longint'(intrinsics[REG_COLOR_CENTER_X]), 15);
			v = reproject_axis(row, dep, longint'(intrinsics[REG_DEPTH_FOCAL_Y]),
				longint'(intrinsics[REG_DEPTH_CENTER_Y]),
				longint'(intrinsics[REG_COLOR_FOCAL_Y]),
				longint'(intrinsics[REG_COLOR_CENTER_Y]), 0);
			if (u > 0 && u < FRAME_W && v > 0 && v < FRAME_H) begin
				t.write_valid = 1'b1;
				t.target_col  = u[COL_W-1:0];
				t.target_row  = v[ROW_W-1:0];
			end
		end
		return t;
	endfunction

	// sender: pops a word on acceptance and records its expected target
	always @(posedge clk or negedge arst_n) begin
		logic took;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			took = s_tvalid && s_tready;
			if (took) begin
				target_q.insert(target_q.size(), predict_target(s_tdata));
				void'(pixel_q.pop_front());
			end
			if (!s_tvalid || took) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each word against the oldest expected target
	always @(posedge clk or negedge arst_n) begin
		target_t got;
		target_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[35:0];
				if (target_q.size() == 0) begin
					$display("%t: unexpected word, actual %h", $realtime, got);
					errors++;
				end else begin
					want = target_q.pop_front();
					if (got.write_valid !== want.write_valid) begin
						$display("%t: write_valid expected %0d actual %0d", $realtime,
							want.write_valid, got.write_valid);
						errors++;
					end
					if (got.target_col !== want.target_col) begin
						$display("%t: target_col expected %0d actual %0d", $realtime,
							want.target_col, got.target_col);
						errors++;
					end
					if (got.target_row !== want.target_row) begin
						$display("%t: target_row expected %0d actual %0d", $realtime,
							want.target_row, got.target_row);
						errors++;
					end
					if (got.depth_out !== want.depth_out) begin
						$display("%t: depth_out expected %0d actual %0d", $realtime,
							want.depth_out, got.depth_out);
						errors++;
					end
				end
			end
			m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		intrinsics[idx] = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(int col, int row, int dep);
		logic [IN_W-1:0] w;
		w = '0;
		w[9:0]   = COL_W'(col);
		w[18:10] = ROW_W'(row);
		w[34:19] = DEPTH_W'(dep);
		pixel_q.insert(pixel_q.size(), w);
	endtask

	// wait for all words out and the pipeline empty
	task automatic drain();
		while (pixel_q.size() > 0 || target_q.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic send_random(int n);
		int k;
		int sel;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			if (sel < 75)
				send_pixel($urandom_range(639), $urandom_range(479),
					$urandom_range(8000, 250));
			else if (sel < 85)
				send_pixel($urandom_range(639), $urandom_range(479), $urandom_range(5));
			else
				send_pixel($urandom_range(639), $urandom_range(479),
					$urandom_range(65535));
		end
	endtask

	// new intrinsics per setup: random, extremes, a zero depth focal length on either axis, plausible random
	task automatic load_setup(int s);
		int r;
		case (s)
			0: begin
				for (r = 0; r < 8; r++)
					write_reg(reg_idx_t'(r), REG_W'($urandom_range(20'hFFFFF)));
			end
			1: begin
				write_reg(REG_DEPTH_FOCAL_X, 20'hFFFFF);
				write_reg(REG_DEPTH_FOCAL_Y, 20'hFFFFF);
				write_reg(REG_DEPTH_CENTER_X, '0);
				write_reg(REG_DEPTH_CENTER_Y, '0);
				write_reg(REG_COLOR_FOCAL_X, 20'hFFFFF);
				write_reg(REG_COLOR_FOCAL_Y, 20'hFFFFF);
				write_reg(REG_COLOR_CENTER_X, '0);
				write_reg(REG_COLOR_CENTER_Y, '0);
			end
			2: begin
				write_reg(REG_DEPTH_FOCAL_X, '0);
				write_reg(REG_DEPTH_FOCAL_Y, RST_FOCAL);
				write_reg(REG_COLOR_CENTER_X, 20'hFFFFF);
				write_reg(REG_COLOR_CENTER_Y, 20'hFFFFF);
			end
			3: begin
				write_reg(REG_DEPTH_FOCAL_X, RST_FOCAL);
				write_reg(REG_DEPTH_FOCAL_Y, '0);
			end
			default: begin
				write_reg(REG_DEPTH_FOCAL_X, REG_W'($urandom_range(900, 100) * 256));
				write_reg(REG_DEPTH_FOCAL_Y, REG_W'($urandom_range(900, 100) * 256));
				write_reg(REG_DEPTH_CENTER_X, REG_W'($urandom_range(400, 240) * 256));
				write_reg(REG_DEPTH_CENTER_Y, REG_W'($urandom_range(300, 180) * 256));
				write_reg(REG_COLOR_FOCAL_X, REG_W'($urandom_range(900, 100) * 256
					+ $urandom_range(255)));
				write_reg(REG_COLOR_FOCAL_Y, REG_W'($urandom_range(900, 100) * 256
					+ $urandom_range(255)));
				write_reg(REG_COLOR_CENTER_X, REG_W'($urandom_range(400, 240) * 256
					+ $urandom_range(255)));
				write_reg(REG_COLOR_CENTER_Y, REG_W'($urandom_range(300, 180) * 256
					+ $urandom_range(255)));
			end
		endcase
		end_writes();
	endtask

	initial begin
		int s;
		intrinsics[REG_DEPTH_FOCAL_X]  = RST_FOCAL;
		intrinsics[REG_DEPTH_FOCAL_Y]  = RST_FOCAL;
		intrinsics[REG_DEPTH_CENTER_X] = RST_CENTER_X;
		intrinsics[REG_DEPTH_CENTER_Y] = RST_CENTER_Y;
		intrinsics[REG_COLOR_FOCAL_X]  = RST_FOCAL;
		intrinsics[REG_COLOR_FOCAL_Y]  = RST_FOCAL;
		intrinsics[REG_COLOR_CENTER_X] = RST_CENTER_X;
		intrinsics[REG_COLOR_CENTER_Y] = RST_CENTER_Y;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 14;
		snk_idle_pct = 67;

		// directed: field extremes, shallow depths, edges of the frame
		send_pixel(320, 240, 1000);
		send_pixel(0, 0, 1000);
		send_pixel(639, 479, 1000);
		send_pixel(639, 0, 65535);
		send_pixel(0, 479, 65535);
		send_pixel(320, 240, 0);
		send_pixel(320, 240, 1);
		send_pixel(320, 240, 2);
		send_pixel(320, 240, 3);
		send_pixel(320, 240, 4);
		send_pixel(1, 1, 300);
		send_pixel(639, 240, 300);
		send_pixel(320, 479, 300);
		send_pixel(10, 10, 27);
		send_pixel(511, 256, 32768);
		send_pixel(512, 255, 16384);
		drain();

		// sender pause mid-run: second half waits for the first to finish
		send_random(150);
		drain();
		send_random(150);
		drain();

		for (s = 0; s < NUM_SETUPS; s++) begin
			if (s == 2) begin
				src_idle_pct = 67;
				snk_idle_pct = 14;
			end else if (s == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			load_setup(s);
			if (s == 4) begin
				// long output stall so the pipeline backs up into the input
				snk_hold <= 1'b1;
				send_random(240);
				repeat (300) @(posedge clk);
				snk_hold <= 1'b0;
			end else begin
				send_random((RAND_ITEMS - 300) / NUM_SETUPS);
			end
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dtcr_pkg.sv
hw/rtl/dtcr_axis.sv
hw/rtl/depth_to_color_reprojection_unit.sv
hw/rtl/dtcr_checker.sv
tb/sv/depth_to_color_reprojection_unit_tb.sv
